// ----- rtl/esd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the event stream decoder.
// No dependencies; every other file of the block imports this package.
package esd_pkg;

  // Command byte codes and class boundaries
  localparam logic [7:0] CMD_NOTE       = 8'h01;
  localparam logic [7:0] CMD_INSTRUMENT = 8'h02;
  localparam logic [7:0] CMD_VOLUME     = 8'h03;
  localparam logic [7:0] CMD_EFFECT     = 8'h04;
  localparam logic [7:0] CMD_PATTERN    = 8'h05;
  localparam logic [7:0] CMD_TRACK      = 8'h06;
  localparam logic [7:0] CMD_ROW        = 8'h41;
  localparam logic [7:0] CMD_LENGTH     = 8'h42;
  localparam logic [7:0] CMD_FX_DATA    = 8'h43;
  localparam logic [7:0] WORD_CMD_BASE  = 8'h40;
  localparam logic [7:0] SKIP4_CMD_BASE = 8'h7F;
  localparam logic [7:0] SKIPN_CMD_BASE = 8'hC0;
  localparam logic [15:0] SKIP4_COUNT   = 16'd4;

  // Effect codes that carry old-style pitch slides
  localparam logic [7:0] FX_SLIDE_E = 8'h45;
  localparam logic [7:0] FX_SLIDE_F = 8'h46;

  // Slide rescale: param * tpb / 24 = ((param * tpb) >> 3) / 3
  localparam int unsigned PROD_W     = 24;
  localparam int unsigned DIV8_SHIFT = 3;
  localparam int unsigned QUO_IN_W   = PROD_W - DIV8_SHIFT;
  localparam int unsigned DIV3_SHIFT = 22;
  // ceil(2^22 / 3): exact floor(x/3) for every x below 2^21
  localparam logic [20:0] DIV3_RECIP = 21'd1398102;

  // Configuration register indexes
  localparam logic CFG_TICKS_PER_BEAT    = 1'b0;
  localparam logic CFG_SLIDES_ON_SUBTICK = 1'b1;
  localparam logic [7:0] TPB_RESET = 8'd4;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef enum logic [2:0] {
    PH_CMD  = 3'd0,
    PH_BYTE = 3'd1,
    PH_WLO  = 3'd2,
    PH_WHI  = 3'd3,
    PH_LLO  = 3'd4,
    PH_LHI  = 3'd5,
    PH_SKIP = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  pattern_index;
    logic [7:0]  track_index;
    logic [15:0] row_index;
    logic [7:0]  note_value;
    logic [7:0]  instrument;
    logic [7:0]  volume;
    logic [7:0]  effect_code;
    logic [15:0] note_length;
    logic [15:0] effect_param;
  } out_item_t;

  // Event as queued between parser and rescaler: raw effect data plus flag
  typedef struct packed {
    out_item_t item;
    logic      scale;
  } evt_t;

  typedef struct packed {
    logic [7:0] ticks_per_beat;
    logic       slides_on_subtick;
  } cfg_t;

endpackage

// ----- rtl/esd_front.sv -----
`timescale 1ns / 1ps
// Byte parser: accepts chunk bytes, tracks parse phase and event state,
// and pushes one event per completed row command. Depends on esd_pkg.
module esd_front
  import esd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     in_stall,
  input  cfg_t     cfg,
  input  logic     q_full,
  output logic     push_valid,
  output evt_t     push_evt
);

  phase_t      phase_r, phase_nxt, e_phase;
  logic [7:0]  cmd_r, cmd_nxt, e_cmd;
  logic [7:0]  low_r, low_nxt, e_low;
  logic [15:0] skip_r, skip_nxt, e_skip;
  logic [7:0]  note_r, note_nxt, e_note;
  logic [7:0]  inst_r, inst_nxt, e_inst;
  logic [7:0]  vol_r, vol_nxt, e_vol;
  logic [7:0]  fx_r, fx_nxt, e_fx;
  logic [15:0] len_r, len_nxt, e_len;
  logic [15:0] fxp_r, fxp_nxt, e_fxp;
  logic [7:0]  pat_r, pat_nxt, e_pat;
  logic [7:0]  trk_r, trk_nxt, e_trk;
  logic        accept;
  logic        row_done;
  logic [7:0]  b;
  logic [15:0] word;
  logic [15:0] skip_dec;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign b        = in_item.data_byte;

  // Chunk start clears running state before the byte is looked at
  always_comb begin
    if (in_item.chunk_start) begin
      e_phase = PH_CMD;
      e_cmd   = '0;
      e_low   = '0;
      e_skip  = '0;
      e_note  = '0;
      e_inst  = '0;
      e_vol   = '0;
      e_fx    = '0;
      e_len   = '0;
      e_fxp   = '0;
      e_pat   = '0;
      e_trk   = '0;
    end else begin
      e_phase = phase_r;
      e_cmd   = cmd_r;
      e_low   = low_r;
      e_skip  = skip_r;
      e_note  = note_r;
      e_inst  = inst_r;
      e_vol   = vol_r;
      e_fx    = fx_r;
      e_len   = len_r;
      e_fxp   = fxp_r;
      e_pat   = pat_r;
      e_trk   = trk_r;
    end
  end

  assign word     = {b, e_low};
  assign skip_dec = (e_skip != '0) ? e_skip - 16'd1 : e_skip;

  always_comb begin
    phase_nxt = e_phase;
    cmd_nxt   = e_cmd;
    low_nxt   = e_low;
    skip_nxt  = e_skip;
    note_nxt  = e_note;
    inst_nxt  = e_inst;
    vol_nxt   = e_vol;
    fx_nxt    = e_fx;
    len_nxt   = e_len;
    fxp_nxt   = e_fxp;
    pat_nxt   = e_pat;
    trk_nxt   = e_trk;
    row_done  = 1'b0;
    unique case (e_phase)
      PH_BYTE: begin
        unique case (e_cmd)
          CMD_NOTE:       note_nxt = b;
          CMD_INSTRUMENT: inst_nxt = b;
          CMD_VOLUME:     vol_nxt  = b;
          CMD_EFFECT:     fx_nxt   = b;
          CMD_PATTERN:    pat_nxt  = b;
          CMD_TRACK:      trk_nxt  = b;
          default: ;
        endcase
        phase_nxt = PH_CMD;
      end
      PH_WLO: begin
        low_nxt   = b;
        phase_nxt = PH_WHI;
      end
      PH_WHI: begin
        priority if (e_cmd == CMD_LENGTH) begin
          len_nxt = word;
        end else if (e_cmd == CMD_FX_DATA) begin
          fxp_nxt = word;
        end else if (e_cmd == CMD_ROW) begin
          row_done = 1'b1;
        end
        phase_nxt = PH_CMD;
      end
      PH_LLO: begin
        low_nxt   = b;
        phase_nxt = PH_LHI;
      end
      PH_LHI: begin
        skip_nxt  = word;
        phase_nxt = (word == '0) ? PH_CMD : PH_SKIP;
      end
      PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = PH_CMD;
        end
      end
      default: begin
        // expecting a command byte
        cmd_nxt = b;
        priority if (b < WORD_CMD_BASE) begin
          phase_nxt = PH_BYTE;
        end else if (b < SKIP4_CMD_BASE) begin
          phase_nxt = PH_WLO;
        end else if (b < SKIPN_CMD_BASE) begin
          skip_nxt  = SKIP4_COUNT;
          phase_nxt = PH_SKIP;
        end else begin
          phase_nxt = PH_LLO;
        end
      end
    endcase
  end

  assign push_valid                  = accept && row_done;
  assign push_evt.item.pattern_index = e_pat;
  assign push_evt.item.track_index   = e_trk;
  assign push_evt.item.row_index     = word;
  assign push_evt.item.note_value    = e_note;
  assign push_evt.item.instrument    = e_inst;
  assign push_evt.item.volume        = e_vol;
  assign push_evt.item.effect_code   = e_fx;
  assign push_evt.item.note_length   = e_len;
  assign push_evt.item.effect_param  = e_fxp;
  assign push_evt.scale = ((e_fx == FX_SLIDE_E) || (e_fx == FX_SLIDE_F)) &&
                          !cfg.slides_on_subtick;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CMD;
      cmd_r   <= '0;
      low_r   <= '0;
      skip_r  <= '0;
      note_r  <= '0;
      inst_r  <= '0;
      vol_r   <= '0;
      fx_r    <= '0;
      len_r   <= '0;
      fxp_r   <= '0;
      pat_r   <= '0;
      trk_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      low_r   <= low_nxt;
      skip_r  <= skip_nxt;
      note_r  <= note_nxt;
      inst_r  <= inst_nxt;
      vol_r   <= vol_nxt;
      fx_r    <= fx_nxt;
      len_r   <= len_nxt;
      fxp_r   <= fxp_nxt;
      pat_r   <= pat_nxt;
      trk_r   <= trk_nxt;
    end
  end

  // Skip phase always has something left to skip
  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> skip_r != '0)
    else $error("skip phase with zero count");

  // Events only leave from the high byte of a row word
  a_push_phase: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> phase_r == PH_WHI && cmd_r == CMD_ROW && !in_item.chunk_start)
    else $error("event pushed outside a row word");

  // No byte is taken while the event queue is full
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push_valid)
    else $error("push into full queue");

endmodule

// ----- rtl/esd_queue.sv -----
`timescale 1ns / 1ps
// Small register FIFO of parsed events between parser and rescaler.
// Depends on esd_pkg for the event type.
module esd_queue
  import esd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  evt_t push_evt,
  output logic full,
  input  logic pop_ready,
  output logic pop_valid,
  output evt_t pop_evt
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  evt_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_evt   = mem_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_ready && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_evt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("queue count lost a push");

  a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop && !do_push |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("queue count lost a pop");

endmodule

// ----- rtl/esd_back.sv -----
`timescale 1ns / 1ps
// Rescaler and output stage: scales old slide data by tpb/24 in two
// multiply stages, then holds the result item. Depends on esd_pkg.
module esd_back
  import esd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  evt_t      q_evt,
  output logic      q_ready,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_stall
);

  logic                       s1_v_r, s1_v_nxt;
  evt_t                       s1_evt_r;
  logic [PROD_W-1:0]          s1_prod_r;
  logic                       s2_v_r, s2_v_nxt;
  out_item_t                  s2_item_r, s2_item_nxt;
  logic                       out_v_r, out_v_nxt;
  out_item_t                  out_item_r;
  logic                       out_free, s2_rdy, s1_rdy;
  logic [QUO_IN_W+20:0]       quo_full;
  logic [15:0]                quo;

  assign out_free = !out_v_r || !out_stall;
  assign s2_rdy   = !s2_v_r || out_free;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign q_ready  = s1_rdy;

  // floor(prod / 24): drop three bits, then divide by 3 by reciprocal
  assign quo_full = (QUO_IN_W+21)'(s1_prod_r[PROD_W-1:DIV8_SHIFT]) *
                    (QUO_IN_W+21)'(DIV3_RECIP);
  assign quo      = quo_full[DIV3_SHIFT +: 16];

  always_comb begin
    s2_item_nxt              = s1_evt_r.item;
    s2_item_nxt.effect_param = s1_evt_r.scale ? quo : s1_evt_r.item.effect_param;
  end

  always_comb begin
    s1_v_nxt  = s1_rdy ? q_valid : s1_v_r;
    s2_v_nxt  = s2_rdy ? s1_v_r : s2_v_r;
    out_v_nxt = out_free ? s2_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && q_valid) begin
      s1_evt_r  <= q_evt;
      s1_prod_r <= PROD_W'(q_evt.item.effect_param) * PROD_W'(cfg.ticks_per_beat);
    end
    if (s2_rdy && s1_v_r) begin
      s2_item_r <= s2_item_nxt;
    end
    if (out_free && s2_v_r) begin
      out_item_r <= s2_item_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s2_rdy |=> s1_v_r && $stable(s1_prod_r))
    else $error("stage 1 dropped a held event");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !out_free |=> s2_v_r && $stable(s2_item_r))
    else $error("stage 2 dropped a held event");

  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_ready |=> s1_v_r)
    else $error("popped event not captured");

endmodule

// ----- rtl/event_stream_decoder_top.sv -----
`timescale 1ns / 1ps
// Top level of the event stream decoder: configuration registers, parser,
// event queue and rescaler. Depends on esd_pkg and the esd_* modules.
//
// The decoder takes one chunk byte per cycle while in_stall is low and
// parses it in the cycle it is accepted. A row command (0x41) completes on
// its high word byte and its event passes through the event queue, then two
// multiply stages that rescale old E/F slide data by ticks_per_beat/24 when
// slides_on_subtick is clear, then the output register. Parsed events wait
// in a QUEUE_DEPTH-entry queue, so output stall reaches the input only once
// that queue is full. Write configuration only while no event is in flight.
module event_stream_decoder_top
  import esd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_item,
  output logic      in_stall,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_stall,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [7:0] cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;
  logic push_valid, q_full, q_valid, q_ready;
  evt_t push_evt, q_evt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_TICKS_PER_BEAT:    cfg_nxt.ticks_per_beat    = cfg_wdata;
        CFG_SLIDES_ON_SUBTICK: cfg_nxt.slides_on_subtick = cfg_wdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_beat    <= TPB_RESET;
      cfg_r.slides_on_subtick <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  esd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .cfg        (cfg_r),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_evt   (push_evt)
  );

  esd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_evt   (push_evt),
    .full       (q_full),
    .pop_ready  (q_ready),
    .pop_valid  (q_valid),
    .pop_evt    (q_evt)
  );

  esd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_evt     (q_evt),
    .q_ready   (q_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

endmodule
